// ----- rtl/ctb_pkg.sv -----
`default_nettype none
package ctb_pkg;

  // Storage size of the gap buffer in bytes
  localparam int CAPACITY_DEFAULT = 4096;

  // Fixed field widths
  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 12;
  localparam int STAT_W = 2;
  localparam int OUT_W  = 13;

  // Command codes on in_command
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BKSP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INS   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // Status codes on out_status
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OOR   = 2'd3;

  // Command queue between front and back
  localparam int QDEPTH = 2;

  // Classified operation
  typedef enum logic [2:0] {
    OP_LEFT,
    OP_RIGHT,
    OP_BKSP,
    OP_INS,
    OP_READ,
    OP_BAD
  } op_t;

  // One queued command
  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  position;
  } q_entry_t;

  // Back end sequencer
  typedef enum logic {
    ST_IDLE,
    ST_MEM
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/ctb_front.sv -----
`default_nettype none
module ctb_front (
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [ctb_pkg::CMD_W-1:0]  in_command,
  input  wire logic [ctb_pkg::CHAR_W-1:0] in_char_in,
  input  wire logic [ctb_pkg::POS_W-1:0]  in_position,
  input  wire logic                      q_full,
  output logic                           q_push,
  output ctb_pkg::q_entry_t              q_push_entry
);
  import ctb_pkg::*;

  op_t op;

  // Decode the command code
  always_comb begin
    unique case (in_command)
      CMD_LEFT:  op = OP_LEFT;
      CMD_RIGHT: op = OP_RIGHT;
      CMD_BKSP:  op = OP_BKSP;
      CMD_INS:   op = OP_INS;
      CMD_READ:  op = OP_READ;
      default:   op = OP_BAD;
    endcase
  end

  // Push into the queue whenever it has room
  assign in_ready              = !q_full;
  assign q_push                = in_valid && !q_full;
  assign q_push_entry.op       = op;
  assign q_push_entry.char_in  = in_char_in;
  assign q_push_entry.position = in_position;

endmodule
`default_nettype wire

// ----- rtl/ctb_queue.sv -----
`default_nettype none
module ctb_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ctb_pkg::q_entry_t push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output ctb_pkg::q_entry_t      entry
);
  import ctb_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  q_entry_t        slot_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == NW'(QDEPTH));
  assign valid   = (count_r != '0);
  assign entry   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ctb_back.sv -----
`default_nettype none
module ctb_back #(
  parameter int CAPACITY = ctb_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire ctb_pkg::q_entry_t          q_entry,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [ctb_pkg::STAT_W-1:0]      out_status,
  output logic [ctb_pkg::CHAR_W-1:0]      out_char_out,
  output logic [ctb_pkg::OUT_W-1:0]       out_text_length,
  output logic [ctb_pkg::OUT_W-1:0]       out_cursor_pos
);
  import ctb_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      left_r, left_nxt;
  logic [CW-1:0]      right_r, right_nxt;
  op_t                pend_op_r, pend_op_nxt;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [OUT_W-1:0]   out_len_r;
  logic [OUT_W-1:0]   out_cur_r;

  logic [CHAR_W-1:0]  text_store_r [CAPACITY];
  logic [CHAR_W-1:0]  rdata_r;

  logic [CW-1:0]      len, gap, left_m1, top_first, top_free, len_nxt;
  logic [MW-1:0]      pos_ext, rd_pos_addr;
  logic               oor, at_start, at_end, is_full, need_mem, out_free;
  logic               mem_re, mem_we, res_load;
  logic [AW-1:0]      mem_ra, mem_wa;
  logic [CHAR_W-1:0]  mem_wd;
  logic [STAT_W-1:0]  res_status;
  logic [CHAR_W-1:0]  res_char;
  logic [31:0]        len32, cur32;

  // Gap bookkeeping
  assign len         = left_r + right_r;
  assign gap         = CAP_C - len;
  assign left_m1     = left_r - CW'(1);
  assign top_first   = CAP_C - right_r;
  assign top_free    = top_first - CW'(1);
  assign pos_ext     = MW'(q_entry.position);
  assign oor         = pos_ext >= MW'(len);
  assign rd_pos_addr = pos_ext + MW'(gap);
  assign at_start    = (left_r == '0);
  assign at_end      = (right_r == '0);
  assign is_full     = (len >= CAP_C);
  assign out_free    = !out_valid_r || out_ready;

  // Commands that need a memory read first
  always_comb begin
    unique case (q_entry.op)
      OP_LEFT:  need_mem = !at_start;
      OP_RIGHT: need_mem = !at_end;
      OP_READ:  need_mem = !oor;
      default:  need_mem = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && need_mem) begin
          state_nxt = ST_MEM;
        end
      end
      ST_MEM: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // Sequencer outputs and count update
  always_comb begin
    q_pop       = 1'b0;
    mem_re      = 1'b0;
    mem_ra      = '0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    res_load    = 1'b0;
    res_status  = STAT_DONE;
    res_char    = '0;
    left_nxt    = left_r;
    right_nxt   = right_r;
    pend_op_nxt = pend_op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && need_mem) begin
          // Issue the read, finish in ST_MEM once the output is free
          q_pop       = 1'b1;
          mem_re      = 1'b1;
          pend_op_nxt = q_entry.op;
          unique case (q_entry.op)
            OP_LEFT:  mem_ra = left_m1[AW-1:0];
            OP_RIGHT: mem_ra = top_first[AW-1:0];
            // Left text sits as is, right text lies beyond the gap
            default:  mem_ra = (pos_ext < MW'(left_r)) ? pos_ext[AW-1:0]
                                                       : rd_pos_addr[AW-1:0];
          endcase
        end else if (q_valid && out_free) begin
          // Commands finished without a memory read
          q_pop    = 1'b1;
          res_load = 1'b1;
          unique case (q_entry.op)
            OP_BKSP: begin
              if (at_start) begin
                res_status = STAT_BOUND;
              end else begin
                left_nxt = left_m1;
              end
            end
            OP_INS: begin
              if (is_full) begin
                res_status = STAT_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = left_r[AW-1:0];
                mem_wd   = q_entry.char_in;
                left_nxt = left_r + CW'(1);
              end
            end
            OP_READ:  res_status = STAT_OOR;
            default:  res_status = STAT_BOUND;
          endcase
        end
      end
      ST_MEM: begin
        if (out_free) begin
          res_load = 1'b1;
          unique case (pend_op_r)
            OP_LEFT: begin
              mem_we    = 1'b1;
              mem_wa    = top_free[AW-1:0];
              mem_wd    = rdata_r;
              left_nxt  = left_m1;
              right_nxt = right_r + CW'(1);
            end
            OP_RIGHT: begin
              mem_we    = 1'b1;
              mem_wa    = left_r[AW-1:0];
              mem_wd    = rdata_r;
              left_nxt  = left_r + CW'(1);
              right_nxt = right_r - CW'(1);
            end
            default: res_char = rdata_r;
          endcase
        end
      end
    endcase
  end

  // Counts reported modulo the field width
  assign len_nxt = left_nxt + right_nxt;
  assign len32   = 32'(len_nxt);
  assign cur32   = 32'(left_nxt);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload and pending command
  always_ff @(posedge clk) begin
    pend_op_r <= pend_op_nxt;
    if (res_load) begin
      out_status_r <= res_status;
      out_char_r   <= res_char;
      out_len_r    <= len32[OUT_W-1:0];
      out_cur_r    <= cur32[OUT_W-1:0];
    end
  end

  // Text memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_store_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= text_store_r[mem_ra];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_char_out    = out_char_r;
  assign out_text_length = out_len_r;
  assign out_cursor_pos  = out_cur_r;

endmodule
`default_nettype wire

// ----- rtl/cursor_text_buffer.sv -----
`default_nettype none
// Line-editor text buffer with a cursor, held as a gap buffer in one RAM.
// Input channel (in_valid/in_ready) carries a command, a byte to insert and
// a text index to read. Result channel (out_valid/out_ready) returns one
// transfer per command: status, byte read, text length and cursor position.
// Commands go into a two-entry queue and are carried out in order.
// Backspace, insert, boundary and invalid cases finish straight from the
// queue; a cursor move or a read that hits text reads the RAM first and
// finishes in ST_MEM. Throughput: one command per cycle for the former
// while results are taken; a move or read holds off the next command until
// ST_MEM is done, set by the single RAM port pair: registered read, then write back.
// Reset empties the text and the queue and drops any pending result; the
// RAM contents are left as they are and are only read where written.
// A stalled result waits in the output register; the queue keeps taking
// commands until it is full, then in_ready falls.
module cursor_text_buffer #(
  parameter int CAPACITY = ctb_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [ctb_pkg::CMD_W-1:0]  in_command,
  input  wire logic [ctb_pkg::CHAR_W-1:0] in_char_in,
  input  wire logic [ctb_pkg::POS_W-1:0]  in_position,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [ctb_pkg::STAT_W-1:0]      out_status,
  output logic [ctb_pkg::CHAR_W-1:0]      out_char_out,
  output logic [ctb_pkg::OUT_W-1:0]       out_text_length,
  output logic [ctb_pkg::OUT_W-1:0]       out_cursor_pos
);
  import ctb_pkg::*;

  logic     q_full, q_push, q_pop, q_valid;
  q_entry_t q_push_entry, q_entry;

  ctb_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_char_in   (in_char_in),
    .in_position  (in_position),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_entry (q_push_entry)
  );

  ctb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .entry      (q_entry)
  );

  ctb_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_char_out    (out_char_out),
    .out_text_length (out_text_length),
    .out_cursor_pos  (out_cursor_pos)
  );

endmodule
`default_nettype wire

// ----- rtl/ctb_checker.sv -----
`default_nettype none
module ctb_checker #(
  parameter int CAPACITY = ctb_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [ctb_pkg::STAT_W-1:0] out_status,
  input  wire logic [ctb_pkg::CHAR_W-1:0] out_char_out,
  input  wire logic [ctb_pkg::OUT_W-1:0]  out_text_length,
  input  wire logic [ctb_pkg::OUT_W-1:0]  out_cursor_pos
);
  import ctb_pkg::*;

  // Counts are exact only while they fit the output fields
  localparam bit EXACT = (CAPACITY < (1 << OUT_W));
  localparam logic [OUT_W-1:0] CAP_O = OUT_W'(CAPACITY);

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_char_out) && $stable(out_text_length) && $stable(out_cursor_pos))
    else $error("stalled result changed");

  // Cursor never passes the end of text
  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    EXACT && out_valid |-> out_cursor_pos <= out_text_length)
    else $error("cursor beyond text length");

  // Dropped insert only when the buffer is full
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    EXACT && out_valid && out_status == STAT_FULL |-> out_text_length == CAP_O)
    else $error("full status with room left");

  // Byte returned only by a successful command
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_DONE |-> out_char_out == '0)
    else $error("byte returned on failed command");

endmodule

bind cursor_text_buffer ctb_checker #(.CAPACITY(CAPACITY)) u_ctb_checker (.*);
`default_nettype wire
